>>> hw/rtl/utrb_pkg.sv
package utrb_pkg;

   localparam int SEND_DEPTH_DEF = 64;
   localparam int RECV_DEPTH_DEF = 64;
   localparam int BYTE_W         = 8;
   localparam int OP_W           = 2;

   typedef enum logic [OP_W-1:0] {
      OP_TX_PUSH   = 2'd0,
      OP_RX_POP    = 2'd1,
      OP_RX_ARRIVE = 2'd2,
      OP_TX_READY  = 2'd3
   } utrb_op_type;

   // occupancy flags of one ring, sampled before the current beat
   typedef struct packed {
      logic empty;
      logic full;
   } utrb_ring_stat_type;

endpackage

>>> hw/rtl/utrb_ram.sv
module utrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/utrb_ring.sv
module utrb_ring #(
   parameter int DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push_en,
   input  logic [utrb_pkg::BYTE_W-1:0]         push_data,
   input  logic                                pop_en,
   output utrb_pkg::utrb_ring_stat_type        status,
   output logic [utrb_pkg::BYTE_W-1:0]         pop_data
);
   import utrb_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic [AW-1:0] head_ff, head_in, head_nxt;
   logic [AW-1:0] tail_ff, tail_in, tail_nxt;

   always_comb begin
      head_nxt = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
      tail_nxt = (tail_ff == AW'(DEPTH - 1)) ? '0 : tail_ff + AW'(1);
   end

   // one slot stays empty so full and empty differ
   assign status.empty = (head_ff == tail_ff);
   assign status.full  = (head_nxt == tail_ff);

   always_comb begin
      head_in = push_en ? head_nxt : head_ff;
      tail_in = pop_en  ? tail_nxt : tail_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   utrb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (push_en),
      .wr_addr (head_ff),
      .wr_data (push_data),
      .rd_en   (pop_en),
      .rd_addr (tail_ff),
      .rd_data (pop_data)
   );

`ifndef ASSERT_OFF
   a_pop_clears_full: assert property (@(posedge clock) disable iff (reset)
      pop_en && !push_en |=> !status.full)
      else $error("ring full right after a pop");
   a_push_moves_head: assert property (@(posedge clock) disable iff (reset)
      push_en |=> head_ff != $past(head_ff) && !status.empty)
      else $error("push did not advance head");
   a_idle_holds_ptrs: assert property (@(posedge clock) disable iff (reset)
      !push_en && !pop_en |=> $stable(head_ff) && $stable(tail_ff))
      else $error("pointers moved without a push or pop");
`endif

endmodule

>>> hw/rtl/uart_tx_rx_ring_buffers_top.sv
// Send and receive byte rings between software and a UART. Each beat on the
// req_ channel carries one operation (transmit push, receive pop, byte arrived
// from the line, transmitter ready) and yields exactly one rsp_ beat. Each ring
// holds DEPTH-1 bytes: one slot stays empty to tell full from empty; a push or
// arrival into a full ring is discarded and flagged on rsp_dropped. A new item
// is taken every cycle unless req_stall is high (stage 1 and the output
// register both full under rsp_stall); its result passes the registered read
// port of the ring memory, then the output register. Pointers and the request
// flag update at acceptance, so back-to-back items see each other's effects.
// Ring memory contents are not cleared by reset, only pointers and flags.
module uart_tx_rx_ring_buffers_top #(
   parameter int SEND_DEPTH = utrb_pkg::SEND_DEPTH_DEF,
   parameter int RECV_DEPTH = utrb_pkg::RECV_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [utrb_pkg::OP_W-1:0]    req_operation,
   input  logic [utrb_pkg::BYTE_W-1:0]  req_data_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_line_valid,
   output logic [utrb_pkg::BYTE_W-1:0]  rsp_line_byte,
   output logic                         rsp_read_valid,
   output logic [utrb_pkg::BYTE_W-1:0]  rsp_read_byte,
   output logic                         rsp_dropped,
   output logic                         rsp_send_request
);
   import utrb_pkg::*;

   utrb_op_type        op;
   logic               accept;
   logic               s1_move;
   utrb_ring_stat_type send_stat, recv_stat;
   logic [BYTE_W-1:0]  send_rd, recv_rd;
   logic               send_push, send_pop, recv_push, recv_pop;
   logic               armed_ff, armed_in;
   logic               dropped_now;

   logic s1_valid_ff, s1_valid_in;
   logic s1_line_ff, s1_read_ff, s1_drop_ff, s1_req_ff;

   logic              out_valid_ff, out_valid_in;
   logic              out_line_ff, out_read_ff, out_drop_ff, out_req_ff;
   logic [BYTE_W-1:0] out_line_byte_ff, out_read_byte_ff;

   assign op = utrb_op_type'(req_operation);

   // stage 1 advances whenever the output register is free or draining
   assign s1_move   = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      send_push   = 1'b0;
      send_pop    = 1'b0;
      recv_push   = 1'b0;
      recv_pop    = 1'b0;
      dropped_now = 1'b0;
      armed_in    = armed_ff;
      if (accept) begin
         unique case (op)
            OP_TX_PUSH: begin
               dropped_now = send_stat.full;
               send_push   = !send_stat.full;
               if (!send_stat.full) begin
                  armed_in = 1'b1;
               end
            end
            OP_RX_POP: begin
               recv_pop = !recv_stat.empty;
            end
            OP_RX_ARRIVE: begin
               dropped_now = recv_stat.full;
               recv_push   = !recv_stat.full;
            end
            OP_TX_READY: begin
               send_pop = armed_ff && !send_stat.empty;
               // disarm once the ring runs dry
               if (armed_ff && send_stat.empty) begin
                  armed_in = 1'b0;
               end
            end
            default: begin
               armed_in = armed_ff;
            end
         endcase
      end
   end

   utrb_ring #(.DEPTH (SEND_DEPTH)) u_send (
      .clock     (clock),
      .reset     (reset),
      .push_en   (send_push),
      .push_data (req_data_byte),
      .pop_en    (send_pop),
      .status    (send_stat),
      .pop_data  (send_rd)
   );

   utrb_ring #(.DEPTH (RECV_DEPTH)) u_recv (
      .clock     (clock),
      .reset     (reset),
      .push_en   (recv_push),
      .push_data (req_data_byte),
      .pop_en    (recv_pop),
      .status    (recv_stat),
      .pop_data  (recv_rd)
   );

   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      out_valid_in = s1_move ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         armed_ff     <= armed_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_line_ff <= send_pop;
         s1_read_ff <= recv_pop;
         s1_drop_ff <= dropped_now;
         s1_req_ff  <= armed_in;
      end
      if (s1_move && s1_valid_ff) begin
         out_line_ff      <= s1_line_ff;
         out_read_ff      <= s1_read_ff;
         out_drop_ff      <= s1_drop_ff;
         out_req_ff       <= s1_req_ff;
         out_line_byte_ff <= s1_line_ff ? send_rd : '0;
         out_read_byte_ff <= s1_read_ff ? recv_rd : '0;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_line_valid   = out_line_ff;
   assign rsp_line_byte    = out_line_byte_ff;
   assign rsp_read_valid   = out_read_ff;
   assign rsp_read_byte    = out_read_byte_ff;
   assign rsp_dropped      = out_drop_ff;
   assign rsp_send_request = out_req_ff;

`ifndef ASSERT_OFF
   a_emit_while_armed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_valid |-> rsp_send_request)
      else $error("byte emitted with request flag clear");
   a_drop_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> !rsp_line_valid && !rsp_read_valid)
      else $error("dropped beat also carries data");
   a_push_arms: assert property (@(posedge clock) disable iff (reset)
      send_push |=> armed_ff)
      else $error("successful push left request disarmed");
`endif

endmodule
